### rtl/http_request_header_tokenizer_assert.svh
// assertion macros for the http request header tokenizer
// needs a clock named clk and a reset named rst in the scope that uses them
`ifndef HTTP_REQUEST_HEADER_TOKENIZER_ASSERT_SVH
`define HTTP_REQUEST_HEADER_TOKENIZER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define HRHT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define HRHT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/hrht_pkg.sv
// shared types and byte codes for the http request header tokenizer
// no dependencies
package hrht_pkg;

  // token kinds as seen on the result channel
  typedef enum logic [2:0] {
    KIND_METHOD    = 3'd0,
    KIND_PATH      = 3'd1,
    KIND_HDR_NAME  = 3'd2,
    KIND_HDR_VALUE = 3'd3,
    KIND_REQ_END   = 3'd4,
    KIND_HDR_END   = 3'd5,
    KIND_COMPLETE  = 3'd6,
    KIND_OVERFLOW  = 3'd7
  } kind_t;

  // field position within the current line
  typedef enum logic [1:0] {
    PH_FIRST  = 2'd0,
    PH_SECOND = 2'd1,
    PH_REST   = 2'd2
  } phase_t;

  // line-level flags
  typedef struct packed {
    logic   cr_pending;
    logic   line_just_ended;
    logic   in_hdr;
    phase_t phase;
  } flags_t;

  // one result item, valid marks that the byte produced one
  typedef struct packed {
    logic       valid;
    kind_t      kind;
    logic [7:0] tbyte;
  } token_t;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SPACE = 8'h20;

endpackage

### rtl/http_request_header_tokenizer.sv
// top level of the http request header tokenizer
// depends on hrht_pkg, hrht_decode and http_request_header_tokenizer_assert.svh
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+-------------------------
//   input    | data_valid / data_ready   | data_byte
//   result   | token_valid / token_ready | token_kind, token_byte
//
// one byte per cycle while the result register is free; an item passes an
// input register and the decode logic, and its token, if any, then enters
// the result register; that register frees in the cycle it is taken, so a
// stalled consumer holds the input register and then data_ready falls
// rst clears all line state and both valid flags
`include "http_request_header_tokenizer_assert.svh"

module http_request_header_tokenizer import hrht_pkg::*; #(
  parameter int LINE_BYTES   = 2048,
  parameter int METHOD_BYTES = 10,
  parameter int PATH_BYTES   = 255
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       data_valid,
  output logic       data_ready,
  input  logic [7:0] data_byte,
  output logic       token_valid,
  input  logic       token_ready,
  output logic [2:0] token_kind,
  output logic [7:0] token_byte
);

  localparam int LCW = $clog2(LINE_BYTES);
  localparam int MCW = $clog2(METHOD_BYTES + 1);
  localparam int PCW = $clog2(PATH_BYTES + 1);

  logic           in_valid;
  logic [7:0]     in_byte;
  flags_t         flags;
  flags_t         flags_next;
  logic [LCW-1:0] line_cnt;
  logic [LCW-1:0] line_cnt_next;
  logic [MCW-1:0] method_cnt;
  logic [MCW-1:0] method_cnt_next;
  logic [PCW-1:0] path_cnt;
  logic [PCW-1:0] path_cnt_next;
  token_t         tok;
  kind_t          out_kind;
  logic [7:0]     out_byte;
  logic           advance;

  // input register moves on when the result register is free
  assign advance    = in_valid && (!token_valid || token_ready);
  assign data_ready = !in_valid || advance;

  hrht_decode #(
    .LINE_BYTES  (LINE_BYTES),
    .METHOD_BYTES(METHOD_BYTES),
    .PATH_BYTES  (PATH_BYTES)
  ) u_decode (
    .in_byte        (in_byte),
    .flags          (flags),
    .line_cnt       (line_cnt),
    .method_cnt     (method_cnt),
    .path_cnt       (path_cnt),
    .flags_next     (flags_next),
    .line_cnt_next  (line_cnt_next),
    .method_cnt_next(method_cnt_next),
    .path_cnt_next  (path_cnt_next),
    .tok            (tok)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (data_ready) begin
      in_valid <= data_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (data_valid && data_ready) begin
      in_byte <= data_byte;
    end
  end

  // line state
  always_ff @(posedge clk) begin
    if (rst) begin
      flags      <= '{cr_pending: 1'b0, line_just_ended: 1'b0,
                      in_hdr: 1'b0, phase: PH_FIRST};
      line_cnt   <= '0;
      method_cnt <= '0;
      path_cnt   <= '0;
    end else if (advance) begin
      flags      <= flags_next;
      line_cnt   <= line_cnt_next;
      method_cnt <= method_cnt_next;
      path_cnt   <= path_cnt_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      token_valid <= 1'b0;
    end else if (advance && tok.valid) begin
      token_valid <= 1'b1;
    end else if (token_ready) begin
      token_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && tok.valid) begin
      out_kind <= tok.kind;
      out_byte <= tok.tbyte;
    end
  end

  assign token_kind = out_kind;
  assign token_byte = out_byte;

  // checks
  `HRHT_ASSERT_NOW(a_marker_byte_zero, token_valid && token_kind[2], token_byte == 8'd0, "marker token carries a nonzero byte")
  `HRHT_ASSERT_NOW(a_line_cnt_bound, 1'b1, line_cnt < LCW'(LINE_BYTES - 1) || line_cnt == LCW'(LINE_BYTES - 1), "line count out of range")
  `HRHT_ASSERT_NOW(a_method_bound, 1'b1, method_cnt <= MCW'(METHOD_BYTES), "method count past limit")
  `HRHT_ASSERT_NEXT(a_restart, advance && tok.valid && (tok.kind == KIND_COMPLETE || tok.kind == KIND_OVERFLOW), !flags.in_hdr && !flags.cr_pending && line_cnt == '0, "no return to start state")

endmodule

### rtl/hrht_decode.sv
// next-state and token logic for one request byte
// depends on hrht_pkg
module hrht_decode import hrht_pkg::*; #(
  parameter int LINE_BYTES   = 2048,
  parameter int METHOD_BYTES = 10,
  parameter int PATH_BYTES   = 255,
  localparam int LCW = $clog2(LINE_BYTES),
  localparam int MCW = $clog2(METHOD_BYTES + 1),
  localparam int PCW = $clog2(PATH_BYTES + 1)
) (
  input  logic [7:0]     in_byte,
  input  flags_t         flags,
  input  logic [LCW-1:0] line_cnt,
  input  logic [MCW-1:0] method_cnt,
  input  logic [PCW-1:0] path_cnt,
  output flags_t         flags_next,
  output logic [LCW-1:0] line_cnt_next,
  output logic [MCW-1:0] method_cnt_next,
  output logic [PCW-1:0] path_cnt_next,
  output token_t         tok
);

  logic [LCW:0] line_inc;

  assign line_inc = {1'b0, line_cnt} + (LCW + 1)'(1);

  always_comb begin
    flags_next      = flags;
    line_cnt_next   = line_cnt;
    method_cnt_next = method_cnt;
    path_cnt_next   = path_cnt;
    tok.valid       = 1'b0;
    tok.kind        = KIND_METHOD;
    tok.tbyte       = 8'd0;

    priority if (in_byte == CH_CR) begin
      // carriage return is never stored
      flags_next.cr_pending = 1'b1;
    end else if (in_byte == CH_LF) begin
      // line end only counts after a carriage return
      if (flags.cr_pending) begin
        tok.valid       = 1'b1;
        line_cnt_next   = '0;
        method_cnt_next = '0;
        path_cnt_next   = '0;
        if (flags.line_just_ended) begin
          // blank line closes the request
          tok.kind   = KIND_COMPLETE;
          flags_next = '{cr_pending: 1'b0, line_just_ended: 1'b0,
                         in_hdr: 1'b0, phase: PH_FIRST};
        end else begin
          tok.kind   = flags.in_hdr ? KIND_HDR_END : KIND_REQ_END;
          flags_next = '{cr_pending: 1'b0, line_just_ended: 1'b1,
                         in_hdr: 1'b1, phase: PH_FIRST};
        end
      end
    end else begin
      flags_next.line_just_ended = 1'b0;
      if (line_inc >= (LCW + 1)'(LINE_BYTES)) begin
        // line too long, back to the start state
        tok.valid       = 1'b1;
        tok.kind        = KIND_OVERFLOW;
        line_cnt_next   = '0;
        method_cnt_next = '0;
        path_cnt_next   = '0;
        flags_next      = '{cr_pending: 1'b0, line_just_ended: 1'b0,
                            in_hdr: 1'b0, phase: PH_FIRST};
      end else begin
        line_cnt_next = line_inc[LCW-1:0];
        if (!flags.in_hdr) begin
          // request line: method, path, then dropped rest
          unique case (flags.phase)
            PH_FIRST: begin
              if (in_byte == CH_SPACE) begin
                flags_next.phase = PH_SECOND;
              end else if (method_cnt < MCW'(METHOD_BYTES)) begin
                method_cnt_next = method_cnt + MCW'(1);
                tok.valid       = 1'b1;
                tok.kind        = KIND_METHOD;
                tok.tbyte       = in_byte;
              end
            end
            PH_SECOND: begin
              if (in_byte == CH_SPACE) begin
                flags_next.phase = PH_REST;
              end else if (path_cnt < PCW'(PATH_BYTES)) begin
                path_cnt_next = path_cnt + PCW'(1);
                tok.valid     = 1'b1;
                tok.kind      = KIND_PATH;
                tok.tbyte     = in_byte;
              end
            end
            default: begin
            end
          endcase
        end else begin
          // header line: name, spaces after the colon, value
          unique case (flags.phase)
            PH_FIRST: begin
              if (in_byte == CH_COLON) begin
                flags_next.phase = PH_SECOND;
              end else begin
                tok.valid = 1'b1;
                tok.kind  = KIND_HDR_NAME;
                tok.tbyte = in_byte;
              end
            end
            PH_SECOND: begin
              if (in_byte != CH_SPACE) begin
                flags_next.phase = PH_REST;
                tok.valid        = 1'b1;
                tok.kind         = KIND_HDR_VALUE;
                tok.tbyte        = in_byte;
              end
            end
            default: begin
              tok.valid = 1'b1;
              tok.kind  = KIND_HDR_VALUE;
              tok.tbyte = in_byte;
            end
          endcase
        end
      end
    end
  end

endmodule
